/* design/complex_rank1_update_core_macros.svh */
// Assertion helpers shared by the design files.
// Each expects clk and arst_n in the scope where it is used.
`ifndef COMPLEX_RANK1_UPDATE_CORE_MACROS_SVH
`define COMPLEX_RANK1_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define CRU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/cru_pkg.sv */
`timescale 1ns / 1ps

package cru_pkg;

	// one complex Q16.16 value, real part in the low half
	typedef struct packed {
		logic signed [31:0] im;
		logic signed [31:0] re;
	} complex_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cmul_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_FIN
	} state_t;

	// operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_COLUMN = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ALPHA_RE  = 2'd0;
	localparam logic [1:0] REG_ALPHA_IM  = 2'd1;
	localparam logic [1:0] REG_ROW_COUNT = 2'd2;

	// partial product order of the complex multiplier
	localparam logic [1:0] TERM_RR = 2'd0;
	localparam logic [1:0] TERM_II = 2'd1;
	localparam logic [1:0] TERM_RI = 2'd2;
	localparam logic [1:0] TERM_IR = 2'd3;
	localparam logic [2:0] MUL_LAST = 3'd4;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// clamp a two-term accumulator to 32 bits
	function automatic logic signed [31:0] sat_acc(input logic signed [48:0] v);
		logic fits;
		fits = (v[48:31] == {18{1'b0}}) || (v[48:31] == {18{1'b1}});
		if (fits)
			return v[31:0];
		return v[48] ? SAT_MIN : SAT_MAX;
	endfunction

	// clamp a 33-bit sum to 32 bits
	function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
		if (v[32] == v[31])
			return v[31:0];
		return v[32] ? SAT_MIN : SAT_MAX;
	endfunction

endpackage

/* design/cru_cmul.sv */
`timescale 1ns / 1ps

// Iterative complex multiply: one 32x32 product per cycle, four products,
// truncated by 16 and summed, result saturated per part.
module cru_cmul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cru_pkg::complex_t   a,
	input  cru_pkg::complex_t   b,
	output cru_pkg::cmul_stat_t stat,
	output cru_pkg::complex_t   res
);

	logic              run_q;
	logic [2:0]        cnt_q;
	cru_pkg::complex_t a_q;
	cru_pkg::complex_t b_q;
	logic signed [63:0] prod_s1;
	logic [1:0]         tag_s1;
	logic signed [48:0] acc_re_q;
	logic signed [48:0] acc_im_q;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic signed [48:0] term;

	assign stat.busy = run_q;
	assign stat.done = run_q && (cnt_q == cru_pkg::MUL_LAST);

	always_comb begin
		case (cnt_q[1:0])
			cru_pkg::TERM_RR: begin mul_a = a_q.re; mul_b = b_q.re; end
			cru_pkg::TERM_II: begin mul_a = a_q.im; mul_b = b_q.im; end
			cru_pkg::TERM_RI: begin mul_a = a_q.re; mul_b = b_q.im; end
			default:          begin mul_a = a_q.im; mul_b = b_q.re; end
		endcase
		mul_p = mul_a * mul_b;
		// floor of product / 2^16
		term = {prod_s1[63], prod_s1[63:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (stat.done)
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= a;
			b_q      <= b;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (run_q) begin
			if (cnt_q != cru_pkg::MUL_LAST) begin
				prod_s1 <= mul_p;
				tag_s1  <= cnt_q[1:0];
			end
			if (cnt_q != 3'd0) begin
				case (tag_s1)
					cru_pkg::TERM_RR: acc_re_q <= acc_re_q + term;
					cru_pkg::TERM_II: acc_re_q <= acc_re_q - term;
					default:          acc_im_q <= acc_im_q + term;
				endcase
			end
		end
	end

	assign res.re = cru_pkg::sat_acc(acc_re_q);
	assign res.im = cru_pkg::sat_acc(acc_im_q);

endmodule

/* design/complex_rank1_update_core.sv */
`timescale 1ns / 1ps
// Complex rank-1 update core: A := alpha*x*y^T + A, Q16.16 per part.
// Input channel (item_valid / item_stall) carries one word per operation:
//   load x element into row_index, start a column with y_j, or update one
//   A element. Output channel (result_valid / result_stall) returns one word
//   per update: the new element, its row, and column_last on the final row.
// Configuration channel (cfg_valid / cfg_ready) writes alpha_real,
//   alpha_imag and row_count by index; it is always ready.
// A load writes the x memory when it is accepted. A column start and an update
//   each use the single shared 32x32 multiplier, which forms the four partial
//   products of each complex multiply one per cycle; an update first reads
//   the x memory through a registered read. An update skips the multiply
//   when the column is skipped because alpha or y_j is zero.
// An update's word enters the output register from the final state, after the
//   read and multiply states (straight from idle to the final state when skipped);
//   the output register lets the next word be accepted while it waits.
// Reset clears alpha to zero, row_count to 256, the column scale to zero and
//   sets the skip flag; the x memory is not cleared and must be loaded first.
// A stalled receiver holds the output word; a further update then waits in
//   its final state until the output register frees.
`include "complex_rank1_update_core_macros.svh"

module complex_rank1_update_core #(
	parameter int MAX_ROWS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value_real,
	input  logic signed [31:0] value_imag,
	input  logic [7:0]         row_index,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] result_real,
	output logic signed [31:0] result_imag,
	output logic [7:0]         result_row,
	output logic               column_last
);

	localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	cru_pkg::state_t     state_q, state_d;
	logic signed [31:0]  alpha_re_q;
	logic signed [31:0]  alpha_im_q;
	logic [8:0]          row_count_q;
	cru_pkg::complex_t   scale_q;
	logic                skip_q;

	// item held through the sequence
	logic [1:0]          op_q;
	cru_pkg::complex_t   val_q;
	logic [7:0]          row_q;
	logic                inrange_q;
	logic                last_q;

	// x memory, one complex word per row
	cru_pkg::complex_t   x_mem [MAX_ROWS];
	cru_pkg::complex_t   rd_q;
	logic [ADDR_W-1:0]   addr;
	logic                in_range;
	logic                mem_we;

	logic                item_acc;
	cru_pkg::complex_t   in_val;
	logic                cmul_start;
	cru_pkg::complex_t   cmul_a;
	cru_pkg::complex_t   cmul_b;
	cru_pkg::cmul_stat_t cmul_stat;
	cru_pkg::complex_t   cmul_res;
	logic                out_load;
	logic                scale_load;
	logic signed [31:0]  upd_re;
	logic signed [31:0]  upd_im;

	assign cfg_ready = 1'b1;
	assign item_acc  = item_valid && !item_stall;
	assign in_val.re = value_real;
	assign in_val.im = value_imag;
	assign addr      = ADDR_W'(row_index);
	assign in_range  = int'(row_index) < MAX_ROWS;
	assign mem_we    = item_acc && (operation == cru_pkg::OP_LOAD) && in_range;

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		cmul_start = 1'b0;
		cmul_a     = '0;
		cmul_b     = '0;
		out_load   = 1'b0;
		scale_load = 1'b0;
		case (state_q)
			cru_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					case (operation)
						cru_pkg::OP_COLUMN: begin
							// t = alpha * y_j
							cmul_start = 1'b1;
							cmul_a.re  = alpha_re_q;
							cmul_a.im  = alpha_im_q;
							cmul_b     = in_val;
							state_d    = cru_pkg::ST_MUL;
						end
						cru_pkg::OP_UPDATE: begin
							state_d = skip_q ? cru_pkg::ST_FIN : cru_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			cru_pkg::ST_READ: begin
				// x word is in rd_q; a row beyond the memory reads as zero
				cmul_start = 1'b1;
				cmul_a     = scale_q;
				cmul_b     = inrange_q ? rd_q : '0;
				state_d    = cru_pkg::ST_MUL;
			end
			cru_pkg::ST_MUL: begin
				if (cmul_stat.done)
					state_d = cru_pkg::ST_FIN;
			end
			cru_pkg::ST_FIN: begin
				if (op_q == cru_pkg::OP_COLUMN) begin
					scale_load = 1'b1;
					state_d    = cru_pkg::ST_IDLE;
				end else if (!result_valid || !result_stall) begin
					out_load = 1'b1;
					state_d  = cru_pkg::ST_IDLE;
				end
			end
			default: state_d = cru_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cru_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers and column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_re_q  <= '0;
			alpha_im_q  <= '0;
			row_count_q <= 9'd256;
			scale_q     <= '0;
			skip_q      <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cru_pkg::REG_ALPHA_RE:  alpha_re_q  <= cfg_data;
					cru_pkg::REG_ALPHA_IM:  alpha_im_q  <= cfg_data;
					cru_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			// skip the column when alpha or y_j is zero
			if (item_acc && operation == cru_pkg::OP_COLUMN)
				skip_q <= ((alpha_re_q == '0) && (alpha_im_q == '0)) ||
					((value_real == '0) && (value_imag == '0));
			if (scale_load)
				scale_q <= cmul_res;
		end
	end

	// hold the accepted word for the rest of its sequence
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q      <= operation;
			val_q     <= in_val;
			row_q     <= row_index;
			inrange_q <= in_range;
			last_q    <= ({1'b0, row_index} + 9'd1) == row_count_q;
		end
	end

	// x memory: write on load, registered read on every accepted word
	always_ff @(posedge clk) begin
		if (mem_we)
			x_mem[addr] <= in_val;
		if (item_acc)
			rd_q <= x_mem[addr];
	end

	cru_cmul u_cmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmul_start),
		.a      (cmul_a),
		.b      (cmul_b),
		.stat   (cmul_stat),
		.res    (cmul_res)
	);

	// a + t*x per part, or pass the element through on a skipped column
	always_comb begin
		if (skip_q) begin
			upd_re = val_q.re;
			upd_im = val_q.im;
		end else begin
			upd_re = cru_pkg::sat_sum({val_q.re[31], val_q.re} + {cmul_res.re[31], cmul_res.re});
			upd_im = cru_pkg::sat_sum({val_q.im[31], val_q.im} + {cmul_res.im[31], cmul_res.im});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (out_load)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_real <= upd_re;
			result_imag <= upd_im;
			result_row  <= row_q;
			column_last <= last_q;
		end
	end

	`CRU_ASSERT_SAME(a_done_in_mul, cmul_stat.done, state_q == cru_pkg::ST_MUL, "multiplier finished outside the multiply state")
	`CRU_ASSERT_SAME(a_start_idle_unit, cmul_start, !cmul_stat.busy, "multiplier started while busy")
	`CRU_ASSERT_SAME(a_read_after_update, state_q == cru_pkg::ST_READ, $past(item_valid && !item_stall && operation == cru_pkg::OP_UPDATE), "memory read state without an update word")
	`CRU_ASSERT_SAME(a_result_from_fin, $rose(result_valid), $past(state_q == cru_pkg::ST_FIN), "result word raised outside the final state")

endmodule
